[hw/rtl/ezr_pkg.sv]
`default_nettype none
package ezr_pkg;
   localparam int ANGLE_BITS      = 16;
   localparam int COEF_FRAC_BITS  = 14;
   localparam int TRIG_ITERATIONS = 16;
   localparam int WORK_FRAC       = 30;
   localparam int FIELD_BITS      = 16;
   localparam int CW              = 33;   // CORDIC x/y width, Q30 plus sign and growth
   localparam int ZW              = 33;   // residual phase width
   localparam int PW              = 33;   // width of a trig value / Q30 product
   localparam logic signed [CW-1:0] CORDIC_X0 = 33'sd652032874;
   localparam logic signed [FIELD_BITS-1:0] COEF_ONE  = 16'sd1 <<< COEF_FRAC_BITS;

   typedef logic [31:0] phase_type;
   typedef logic signed [PW-1:0] q30_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
      logic                  order_error;
   } rsp_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] roll_angle, pitch_angle, yaw_angle;
      logic                  axis_order;
   } req_type;

   function automatic logic [31:0] atan_phase(input logic [4:0] i);
      logic [31:0] t;
      case (i)
         5'd0:  t = 32'h20000000; 5'd1:  t = 32'h12E4051E;
         5'd2:  t = 32'h09FB385B; 5'd3:  t = 32'h051111D4;
         5'd4:  t = 32'h028B0D43; 5'd5:  t = 32'h0145D7E1;
         5'd6:  t = 32'h00A2F61E; 5'd7:  t = 32'h00517C55;
         5'd8:  t = 32'h0028BE53; 5'd9:  t = 32'h00145F2F;
         5'd10: t = 32'h000A2F98; 5'd11: t = 32'h000517CC;
         5'd12: t = 32'h00028BE6; 5'd13: t = 32'h000145F3;
         5'd14: t = 32'h0000A2FA; 5'd15: t = 32'h0000517D;
         5'd16: t = 32'h000028BE; 5'd17: t = 32'h0000145F;
         5'd18: t = 32'h00000A30; 5'd19: t = 32'h00000518;
         5'd20: t = 32'h0000028C; 5'd21: t = 32'h00000146;
         5'd22: t = 32'h000000A3; 5'd23: t = 32'h00000051;
         5'd24: t = 32'h00000029; 5'd25: t = 32'h00000014;
         5'd26: t = 32'h0000000A; 5'd27: t = 32'h00000005;
         5'd28: t = 32'h00000003; 5'd29: t = 32'h00000001;
         5'd30: t = 32'h00000001; default: t = 32'h00000000;
      endcase
      return t;
   endfunction

   // Q30 product, floor shift
   function automatic q30_type qmul(input q30_type a, input q30_type b);
      logic signed [2*PW-1:0] p;
      p = a * b;
      return q30_type'(p >>> WORK_FRAC);
   endfunction

   function automatic logic [FIELD_BITS-1:0] to_coef(input logic signed [PW+1:0] v);
      logic signed [PW+1:0] r;
      r = (v + (PW+2)'(1 <<< (WORK_FRAC-COEF_FRAC_BITS-1))) >>> (WORK_FRAC-COEF_FRAC_BITS);
      if (r > (PW+2)'(COEF_ONE)) r = (PW+2)'(COEF_ONE);
      if (r < -(PW+2)'(COEF_ONE)) r = -(PW+2)'(COEF_ONE);
      return r[FIELD_BITS-1:0];
   endfunction
endpackage
`default_nettype wire

[hw/rtl/ezr_stream_if.sv]
`default_nettype none
interface ezr_stream_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface
`default_nettype wire

[hw/rtl/ezr_cordic_stage.sv]
`default_nettype none
// One CORDIC micro-rotation for all three angles, registered.
module ezr_cordic_stage (
   input  wire                         clock,
   input  wire                         enable,
   input  wire logic [4:0]             step,
   input  wire logic signed [ezr_pkg::CW-1:0] x_in [3],
   input  wire logic signed [ezr_pkg::CW-1:0] y_in [3],
   input  wire logic signed [ezr_pkg::ZW-1:0] z_in [3],
   output logic signed [ezr_pkg::CW-1:0]      x_ff [3],
   output logic signed [ezr_pkg::CW-1:0]      y_ff [3],
   output logic signed [ezr_pkg::ZW-1:0]      z_ff [3]
);
   logic signed [ezr_pkg::ZW-1:0] atan_step;
   logic signed [ezr_pkg::CW-1:0] x_in_n [3], y_in_n [3];
   logic signed [ezr_pkg::ZW-1:0] z_in_n [3];

   // step is tied to a constant at each instance, so the shifts reduce to wiring
   assign atan_step = ezr_pkg::ZW'(ezr_pkg::atan_phase(step));

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (!z_in[a][ezr_pkg::ZW-1]) begin
            x_in_n[a] = x_in[a] - (y_in[a] >>> step);
            y_in_n[a] = y_in[a] + (x_in[a] >>> step);
            z_in_n[a] = z_in[a] - atan_step;
         end else begin
            x_in_n[a] = x_in[a] + (y_in[a] >>> step);
            y_in_n[a] = y_in[a] - (x_in[a] >>> step);
            z_in_n[a] = z_in[a] + atan_step;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff <= x_in_n;
         y_ff <= y_in_n;
         z_ff <= z_in_n;
      end
   end
endmodule
`default_nettype wire

[hw/rtl/euler_zyx_to_rotation_matrix.sv]
`default_nettype none
// channel  | ports                     | payload
// request  | req_valid / req_ready     | roll, pitch, yaw angle, axis order
// response | rsp_valid / rsp_ready     | m00..m22 Q2.14, order_error
//
// Stages: input, 16 CORDIC, quadrant, 2 multiply, output.
// One transaction per cycle sustained while the output is not stalled; the CORDIC chain sets the depth.
// Reset clears only the valid bits of the stages.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
module euler_zyx_to_rotation_matrix (
   input  wire  clock,
   input  wire  reset,
   ezr_stream_if.sink   req,
   ezr_stream_if.source rsp
);
   localparam int NS = ezr_pkg::TRIG_ITERATIONS + 5;
   localparam int N  = ezr_pkg::TRIG_ITERATIONS;

   logic [NS-1:0] valid_ff, valid_in;
   logic          advance;
   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   always_comb begin
      valid_in = {valid_ff[NS-2:0], req.valid};
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end
   assign rsp.valid = valid_ff[NS-1];

   // order flag travels alongside
   logic [NS-2:0] err_ff;
   always_ff @(posedge clock) begin
      if (advance) err_ff <= {err_ff[NS-3:0], req.payload.axis_order};
   end

   // input stage: phase split
   logic [1:0] quad_ff [N+1][3];
   logic signed [ezr_pkg::CW-1:0] x0_ff [3], y0_ff [3];
   logic signed [ezr_pkg::ZW-1:0] z0_ff [3];
   logic signed [ezr_pkg::CW-1:0] cx [N+1][3];
   logic signed [ezr_pkg::CW-1:0] cy [N+1][3];
   logic signed [ezr_pkg::ZW-1:0] cz [N+1][3];
   logic [ezr_pkg::FIELD_BITS-1:0] ang [3];
   assign ang[0] = req.payload.roll_angle;
   assign ang[1] = req.payload.pitch_angle;
   assign ang[2] = req.payload.yaw_angle;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int a = 0; a < 3; a++) begin
            ezr_pkg::phase_type ph;
            ph = ezr_pkg::phase_type'(ang[a][ezr_pkg::ANGLE_BITS-1:0])
                 << (32 - ezr_pkg::ANGLE_BITS);
            quad_ff[0][a] <= ph[31:30];
            x0_ff[a] <= ezr_pkg::CORDIC_X0;
            y0_ff[a] <= '0;
            z0_ff[a] <= ezr_pkg::ZW'(ph[29:0]);
         end
         for (int k = 1; k < N+1; k++) quad_ff[k] <= quad_ff[k-1];
      end
   end
   assign cx[0] = x0_ff;
   assign cy[0] = y0_ff;
   assign cz[0] = z0_ff;

   for (genvar i = 0; i < N; i++) begin : g_cordic
      ezr_cordic_stage u_stage (
         .clock(clock), .enable(advance), .step(5'(i)),
         .x_in(cx[i]), .y_in(cy[i]), .z_in(cz[i]),
         .x_ff(cx[i+1]), .y_ff(cy[i+1]), .z_ff(cz[i+1])
      );
   end

   // quadrant fold
   ezr_pkg::q30_type c_ff [3], s_ff [3];
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int a = 0; a < 3; a++) begin
            case (quad_ff[N][a])
               2'd0:    begin c_ff[a] <= cx[N][a];  s_ff[a] <= cy[N][a];  end
               2'd1:    begin c_ff[a] <= -cy[N][a]; s_ff[a] <= cx[N][a];  end
               2'd2:    begin c_ff[a] <= -cx[N][a]; s_ff[a] <= -cy[N][a]; end
               default: begin c_ff[a] <= cy[N][a];  s_ff[a] <= -cx[N][a]; end
            endcase
         end
      end
   end

   // first products
   ezr_pkg::q30_type sxsy_ff, cxsy_ff, m00_ff, m10_ff, m21_ff, m22_ff, cxsz_ff, sxsz_ff;
   ezr_pkg::q30_type cxcz_ff, sxcz_ff, sy_ff, sz_ff, cz_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         sxsy_ff <= ezr_pkg::qmul(s_ff[0], s_ff[1]);
         cxsy_ff <= ezr_pkg::qmul(c_ff[0], s_ff[1]);
         m00_ff  <= ezr_pkg::qmul(c_ff[1], c_ff[2]);
         m10_ff  <= ezr_pkg::qmul(c_ff[1], s_ff[2]);
         m21_ff  <= ezr_pkg::qmul(s_ff[0], c_ff[1]);
         m22_ff  <= ezr_pkg::qmul(c_ff[0], c_ff[1]);
         cxsz_ff <= ezr_pkg::qmul(c_ff[0], s_ff[2]);
         sxsz_ff <= ezr_pkg::qmul(s_ff[0], s_ff[2]);
         cxcz_ff <= ezr_pkg::qmul(c_ff[0], c_ff[2]);
         sxcz_ff <= ezr_pkg::qmul(s_ff[0], c_ff[2]);
         sy_ff   <= s_ff[1];
         sz_ff   <= s_ff[2];
         cz_ff   <= c_ff[2];
      end
   end

   // second products and sums
   localparam int SW = ezr_pkg::PW + 2;
   logic signed [SW-1:0] e01_ff, e02_ff, e11_ff, e12_ff;
   logic signed [SW-1:0] t00_ff, t10_ff, t20_ff, t21_ff, t22_ff;
   always_ff @(posedge clock) begin
      if (advance) begin
         e01_ff <= SW'(ezr_pkg::qmul(sxsy_ff, cz_ff)) - SW'(cxsz_ff);
         e02_ff <= SW'(ezr_pkg::qmul(cxsy_ff, cz_ff)) + SW'(sxsz_ff);
         e11_ff <= SW'(ezr_pkg::qmul(sxsy_ff, sz_ff)) + SW'(cxcz_ff);
         e12_ff <= SW'(ezr_pkg::qmul(cxsy_ff, sz_ff)) - SW'(sxcz_ff);
         t00_ff <= SW'(m00_ff);
         t10_ff <= SW'(m10_ff);
         t20_ff <= -SW'(sy_ff);
         t21_ff <= SW'(m21_ff);
         t22_ff <= SW'(m22_ff);
      end
   end

   // round and clamp
   ezr_pkg::rsp_type out_ff, out_in;
   always_comb begin
      out_in.m00 = ezr_pkg::to_coef(t00_ff);
      out_in.m01 = ezr_pkg::to_coef(e01_ff);
      out_in.m02 = ezr_pkg::to_coef(e02_ff);
      out_in.m10 = ezr_pkg::to_coef(t10_ff);
      out_in.m11 = ezr_pkg::to_coef(e11_ff);
      out_in.m12 = ezr_pkg::to_coef(e12_ff);
      out_in.m20 = ezr_pkg::to_coef(t20_ff);
      out_in.m21 = ezr_pkg::to_coef(t21_ff);
      out_in.m22 = ezr_pkg::to_coef(t22_ff);
      out_in.order_error = 1'b0;
      if (err_ff[NS-2]) begin
         out_in = '0;
         out_in.order_error = 1'b1;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) out_ff <= out_in;
   end
   assign rsp.payload = out_ff;

`ifndef ASSERT_OFF
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.ready |=> $stable(valid_ff))
      else $error("pipeline moved under stall");
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.payload.order_error |-> rsp.payload.m00 == '0 && rsp.payload.m22 == '0)
      else $error("order error with nonzero matrix");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp.valid |-> req.ready)
      else $error("stalled with empty output");
`endif
endmodule
`default_nettype wire
